/* src/vdsr_pkg.sv */
package vdsr_pkg;

   localparam int NUM_ATTR        = 8;
   localparam int ATTR_W          = 32;
   localparam int VTX_W           = NUM_ATTR * ATTR_W;
   localparam int IDX_W           = 5;
   localparam int DEF_MAX_CORNERS = 32;
   localparam int RSP_DATA_W      = 264;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_CORNER = 1'b1;

   typedef enum logic [3:0] {
      S_COLLECT,
      S_P1,
      S_P1_RES,
      S_P2,
      S_P2_RES,
      S_CMP_LAT,
      S_CMP_GO,
      S_CMP_WAIT,
      S_V_SET,
      S_V_LAT,
      S_V_OUT,
      S_C_OUT
   } state_type;

   typedef struct packed {
      logic done;
      logic lt;
      logic eq;
   } cmp_res_type;

   // float bit pattern to an unsigned key in float order, -0 folded onto +0
   function automatic logic [ATTR_W-1:0] order_key(input logic [ATTR_W-1:0] bits);
      logic [ATTR_W-1:0] b;
      b = bits;
      if (b == {1'b1, {(ATTR_W-1){1'b0}}}) begin
         b = '0;
      end
      if (b[ATTR_W-1]) begin
         return ~b;
      end
      return b | {1'b1, {(ATTR_W-1){1'b0}}};
   endfunction

endpackage

/* src/vertex_dedup_sort_remap.sv */
// channel  | ports               | contents
// request  | req_tdata/tlast     | 8 attributes, last corner mark
// response | rsp_tdata/tuser/... | index, attributes, overflow; kind; last result
//
// requests are accepted while collecting; the corner lands in the vertex ram, or sets the overflow flag once it is full
// on the last request the block goes busy: up to n*(n-1)/2 + n*(n-1) compares, each through
// step, ram read, start, one attribute per cycle and result step; then the vertex responses,
// each through set, ram read and output steps, and the corner responses, all held by response stalls
// reset clears the state machine, corner count and overflow flag; the ram is not cleared
// while busy or emitting, req_tready stays low
module vertex_dedup_sort_remap
   import vdsr_pkg::*;
#(
   parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VTX_W-1:0]      req_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // new_index, out_pos_x .. out_tex_v, overflow, zero fill
   output logic                  rsp_tuser,  // record_kind
   output logic                  rsp_tlast
);

   localparam int AW    = $clog2(MAX_CORNERS);
   localparam int CNT_W = $clog2(MAX_CORNERS + 1);

   state_type        state_ff, state_in;
   logic             ret_p2_ff, ret_p2_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, dist_ff, dist_in, k_ff, k_in;
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    acc_ff, acc_in, rd_a_ff, rd_a_in, rd_b_ff, rd_b_in;

   logic             first_ff [MAX_CORNERS];
   logic [AW-1:0]    rep_ff [MAX_CORNERS];
   logic [AW-1:0]    rank_ff [MAX_CORNERS];
   logic [AW-1:0]    sorted_ff [MAX_CORNERS];

   logic             first_we, first_wd, rep_we, rank_we;
   logic [AW-1:0]    rep_wd;

   logic             wr_en, cmp_start;
   logic [VTX_W-1:0] a_data, b_data;
   cmp_res_type      cmp_res;
   logic [AW-1:0]    ii, jj;
   logic [IDX_W-1:0] out_idx;
   logic             accept, rsp_take;

   assign ii       = i_ff[AW-1:0];
   assign jj       = j_ff[AW-1:0];
   assign accept   = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign wr_en    = accept && (cnt_ff < CNT_W'(MAX_CORNERS));

   vdsr_ram #(.WIDTH(VTX_W), .DEPTH(MAX_CORNERS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_a_ff),
      .rd_data (a_data)
   );

   vdsr_ram #(.WIDTH(VTX_W), .DEPTH(MAX_CORNERS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_b_ff),
      .rd_data (b_data)
   );

   vdsr_cmp u_cmp (
      .clock  (clock),
      .reset  (reset),
      .start  (cmp_start),
      .a_data (a_data),
      .b_data (b_data),
      .res    (cmp_res)
   );

   always_comb begin
      state_in  = state_ff;
      ret_p2_in = ret_p2_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      dist_in   = dist_ff;
      k_in      = k_ff;
      rd_a_in   = rd_a_ff;
      rd_b_in   = rd_b_ff;
      first_we  = 1'b0;
      first_wd  = 1'b0;
      rep_we    = 1'b0;
      rep_wd    = jj;
      rank_we   = 1'b0;
      cmp_start = 1'b0;
      unique case (state_ff)
         S_COLLECT: begin
            if (accept) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = S_P1;
               end
            end
         end
         S_P1: begin
            if (i_ff == cnt_ff) begin
               i_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               dist_in  = '0;
               state_in = S_P2;
            end else if (j_ff == i_ff) begin
               first_we = 1'b1;
               first_wd = 1'b1;
               rep_we   = 1'b1;
               rep_wd   = ii;
               i_in     = i_ff + 1'b1;
               j_in     = '0;
            end else begin
               rd_a_in   = jj;
               rd_b_in   = ii;
               ret_p2_in = 1'b0;
               state_in  = S_CMP_LAT;
            end
         end
         S_P1_RES: begin
            if (cmp_res.eq) begin
               first_we = 1'b1;
               first_wd = 1'b0;
               rep_we   = 1'b1;
               rep_wd   = jj;
               i_in     = i_ff + 1'b1;
               j_in     = '0;
            end else begin
               j_in = j_ff + 1'b1;
            end
            state_in = S_P1;
         end
         S_P2: begin
            if (i_ff == cnt_ff) begin
               k_in     = '0;
               state_in = S_V_SET;
            end else if (!first_ff[ii]) begin
               i_in = i_ff + 1'b1;
            end else if (j_ff == cnt_ff) begin
               rank_we = 1'b1;
               dist_in = dist_ff + 1'b1;
               i_in    = i_ff + 1'b1;
               j_in    = '0;
               acc_in  = '0;
            end else if (!first_ff[jj] || j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               rd_a_in   = jj;
               rd_b_in   = ii;
               ret_p2_in = 1'b1;
               state_in  = S_CMP_LAT;
            end
         end
         S_P2_RES: begin
            if (cmp_res.lt) begin
               acc_in = acc_ff + 1'b1;
            end
            j_in     = j_ff + 1'b1;
            state_in = S_P2;
         end
         S_CMP_LAT: begin
            state_in = S_CMP_GO;
         end
         S_CMP_GO: begin
            cmp_start = 1'b1;
            state_in  = S_CMP_WAIT;
         end
         S_CMP_WAIT: begin
            if (cmp_res.done) begin
               state_in = ret_p2_ff ? S_P2_RES : S_P1_RES;
            end
         end
         S_V_SET: begin
            rd_a_in  = sorted_ff[k_ff[AW-1:0]];
            state_in = S_V_LAT;
         end
         S_V_LAT: begin
            state_in = S_V_OUT;
         end
         S_V_OUT: begin
            if (rsp_take) begin
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == dist_ff) begin
                  i_in     = '0;
                  state_in = S_C_OUT;
               end else begin
                  state_in = S_V_SET;
               end
            end
         end
         S_C_OUT: begin
            if (rsp_take) begin
               if (i_ff + 1'b1 == cnt_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_COLLECT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_p2_ff <= ret_p2_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      acc_ff    <= acc_in;
      dist_ff   <= dist_in;
      k_ff      <= k_in;
      rd_a_ff   <= rd_a_in;
      rd_b_ff   <= rd_b_in;
      if (first_we) begin
         first_ff[ii] <= first_wd;
      end
      if (rep_we) begin
         rep_ff[ii] <= rep_wd;
      end
      if (rank_we) begin
         rank_ff[ii]       <= acc_ff;
         sorted_ff[acc_ff] <= ii;
      end
   end

   assign req_tready = (state_ff == S_COLLECT);
   assign rsp_tvalid = (state_ff == S_V_OUT) || (state_ff == S_C_OUT);
   assign rsp_tuser  = (state_ff == S_C_OUT) ? KIND_CORNER : KIND_VERTEX;
   assign rsp_tlast  = (state_ff == S_C_OUT) && (i_ff + 1'b1 == cnt_ff);
   assign out_idx    = (state_ff == S_C_OUT) ? IDX_W'(rank_ff[rep_ff[ii]])
                                             : IDX_W'(k_ff[AW-1:0]);

   always_comb begin
      rsp_tdata                       = '0;
      rsp_tdata[IDX_W-1:0]            = out_idx;
      rsp_tdata[IDX_W +: VTX_W]       = (state_ff == S_V_OUT) ? a_data : '0;
      rsp_tdata[IDX_W + VTX_W]        = ovf_ff;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("response and request sides active together");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_CORNERS))
      else $error("corner count beyond capacity");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_CORNER))
      else $error("last result is not a corner record");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      $past(cmp_start) |-> !cmp_res.done)
      else $error("compare finished without working");

endmodule

/* src/vdsr_ram.sv */
module vdsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/vdsr_cmp.sv */
module vdsr_cmp
   import vdsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VTX_W-1:0] a_data,
   input  logic [VTX_W-1:0] b_data,
   output cmp_res_type      res
);

   logic                        busy_ff, busy_in;
   logic [$clog2(NUM_ATTR)-1:0] f_ff, f_in;
   cmp_res_type                 res_ff, res_in;
   logic [ATTR_W-1:0]           ka, kb;

   always_comb begin
      ka      = order_key(a_data[f_ff*ATTR_W +: ATTR_W]);
      kb      = order_key(b_data[f_ff*ATTR_W +: ATTR_W]);
      busy_in = busy_ff;
      f_in    = f_ff;
      res_in  = res_ff;
      res_in.done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         f_in    = '0;
      end else if (busy_ff) begin
         if (ka != kb || f_ff == $clog2(NUM_ATTR)'(NUM_ATTR - 1)) begin
            busy_in     = 1'b0;
            res_in.done = 1'b1;
            res_in.lt   = ka < kb;
            res_in.eq   = ka == kb;
         end else begin
            f_in = f_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         f_ff    <= '0;
         res_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         f_ff    <= f_in;
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

/* verif/vertex_remap_checker.sv */
`timescale 1ns / 1ps

module vertex_remap_checker
   import vdsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [VTX_W-1:0]      req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    pending,
   output int                    run_count,
   output int                    record_count,
   output int                    overflow_runs
);

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] index;
      logic [VTX_W-1:0] vertex;
      logic             ovf;
      logic             last;
   } remap_record_type;

   logic [VTX_W-1:0] held_corners[$];
   logic             dropped_corner;
   remap_record_type expected_records[$];

   function automatic logic [ATTR_W-1:0] float_rank(input logic [ATTR_W-1:0] f);
      logic [ATTR_W-1:0] v;
      v = (f == 32'h8000_0000) ? '0 : f;
      return v[ATTR_W-1] ? ~v : (v | 32'h8000_0000);
   endfunction

   function automatic int vertex_order(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
      logic [ATTR_W-1:0] ka, kb;
      for (int f = 0; f < NUM_ATTR; f++) begin
         ka = float_rank(a[f*ATTR_W +: ATTR_W]);
         kb = float_rank(b[f*ATTR_W +: ATTR_W]);
         if (ka < kb) return -1;
         if (ka > kb) return 1;
      end
      return 0;
   endfunction

   task automatic predict_run();
      int               rep_of[DEF_MAX_CORNERS];
      int               reps[$];
      int               rank_of[DEF_MAX_CORNERS];
      int               n, tmp, k;
      remap_record_type rec;
      n = held_corners.size();
      for (int i = 0; i < n; i++) begin
         rep_of[i] = i;
         for (int j = 0; j < i; j++) begin
            if (vertex_order(held_corners[j], held_corners[i]) == 0) begin
               rep_of[i] = j;
               break;
            end
         end
         if (rep_of[i] == i) reps.insert(reps.size(), i);
      end
      for (int i = 1; i < reps.size(); i++) begin
         k = i;
         while (k > 0 && vertex_order(held_corners[reps[k]], held_corners[reps[k-1]]) < 0) begin
            tmp = reps[k];
            reps[k] = reps[k-1];
            reps[k-1] = tmp;
            k--;
         end
      end
      foreach (reps[r]) begin
         rank_of[reps[r]] = r;
         rec.kind   = KIND_VERTEX;
         rec.index  = r[IDX_W-1:0];
         rec.vertex = held_corners[reps[r]];
         rec.ovf    = dropped_corner;
         rec.last   = 1'b0;
         expected_records.insert(expected_records.size(), rec);
      end
      for (int i = 0; i < n; i++) begin
         rec.kind   = KIND_CORNER;
         rec.index  = rank_of[rep_of[i]][IDX_W-1:0];
         rec.vertex = '0;
         rec.ovf    = dropped_corner;
         rec.last   = (i == n - 1);
         expected_records.insert(expected_records.size(), rec);
      end
      run_count++;
      if (dropped_corner) overflow_runs++;
   endtask

   always @(posedge clock) begin
      remap_record_type exp_rec;
      if (reset) begin
         held_corners.delete();
         dropped_corner = 1'b0;
         fail_count     = 0;
         run_count      = 0;
         record_count   = 0;
         overflow_runs  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (held_corners.size() < DEF_MAX_CORNERS)
               held_corners.insert(held_corners.size(), req_tdata);
            else dropped_corner = 1'b1;
            if (req_tlast) begin
               predict_run();
               held_corners.delete();
               dropped_corner = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            record_count++;
            if (expected_records.size() == 0) begin
               $error("unexpected response kind=%0b index=%0d", rsp_tuser, rsp_tdata[4:0]);
               fail_count++;
            end else begin
               exp_rec = expected_records.pop_front();
               if (rsp_tuser !== exp_rec.kind) begin
                  $error("record_kind expected %0b actual %0b", exp_rec.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[IDX_W-1:0] !== exp_rec.index) begin
                  $error("new_index expected %0d actual %0d", exp_rec.index,
                         rsp_tdata[IDX_W-1:0]);
                  fail_count++;
               end
               for (int f = 0; f < NUM_ATTR; f++) begin
                  if (rsp_tdata[IDX_W + f*ATTR_W +: ATTR_W] !==
                      exp_rec.vertex[f*ATTR_W +: ATTR_W]) begin
                     $error("attribute %0d expected %h actual %h", f,
                            exp_rec.vertex[f*ATTR_W +: ATTR_W],
                            rsp_tdata[IDX_W + f*ATTR_W +: ATTR_W]);
                     fail_count++;
                  end
               end
               if (rsp_tdata[IDX_W + VTX_W] !== exp_rec.ovf) begin
                  $error("overflow expected %0b actual %0b", exp_rec.ovf,
                         rsp_tdata[IDX_W + VTX_W]);
                  fail_count++;
               end
               if (rsp_tlast !== exp_rec.last) begin
                  $error("last_result expected %0b actual %0b", exp_rec.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_records.size();
   end

endmodule

/* verif/tb_vertex_dedup_sort_remap.sv */
`timescale 1ns / 1ps

module tb_vertex_dedup_sort_remap;
   import vdsr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VTX_W-1:0]      req_tdata = '0;  // pos_x .. tex_v
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // new_index, attributes, overflow, zero fill
   logic                  rsp_tuser;  // record_kind
   logic                  rsp_tlast;

   int  fail_count, pending, run_count, record_count, overflow_runs;
   bit  quiet = 1'b0;
   int  corners_sent = 0;
   int  sink_stall = 0;
   logic [VTX_W-1:0] run_vertices[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vertex_dedup_sort_remap dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   vertex_remap_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending), .run_count(run_count),
      .record_count(record_count), .overflow_runs(overflow_runs)
   );

   // response side stalls in bursts
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_tready <= 1'b1;
         sink_stall <= 0;
      end else if (sink_stall > 0) begin
         rsp_tready <= 1'b0;
         sink_stall <= sink_stall - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         sink_stall <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [ATTR_W-1:0] pick_float();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7f80_0000;
         3: return 32'hff80_0000;
         4: return 32'h7fc0_0001;
         5: return 32'hffff_ffff;
         6: return 32'h3f80_0000;
         7: return 32'hbf80_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [VTX_W-1:0] make_vertex();
      logic [VTX_W-1:0] v;
      logic [VTX_W-1:0] old;
      if (run_vertices.size() > 0 && $urandom_range(0, 2) == 0) begin
         old = run_vertices[$urandom_range(0, run_vertices.size() - 1)];
         v = old;
         for (int f = 0; f < NUM_ATTR; f++) begin
            if ((old[f*ATTR_W +: ATTR_W] & 32'h7fff_ffff) == 0 && $urandom_range(0, 1))
               v[f*ATTR_W + ATTR_W - 1] = ~old[f*ATTR_W + ATTR_W - 1];
         end
         // near miss on one attribute
         if ($urandom_range(0, 3) == 0)
            v[$urandom_range(0, NUM_ATTR - 1)*ATTR_W +: ATTR_W] = pick_float();
      end else begin
         for (int f = 0; f < NUM_ATTR; f++) v[f*ATTR_W +: ATTR_W] = pick_float();
      end
      return v;
   endfunction

   task automatic send_corner(input logic [VTX_W-1:0] v, input logic last);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      run_vertices.insert(run_vertices.size(), v);
      if (last) run_vertices.delete();
      corners_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input int n);
      for (int i = 0; i < n; i++) send_corner(make_vertex(), i == n - 1);
   endtask

   initial begin
      logic [VTX_W-1:0] v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // signed zeros, infinities, nans, extremes, duplicates
      v = '0;
      send_corner(v, 1'b0);
      for (int f = 0; f < NUM_ATTR; f++) v[f*ATTR_W +: ATTR_W] = 32'h8000_0000;
      send_corner(v, 1'b0);
      send_corner({VTX_W{1'b1}}, 1'b0);
      for (int f = 0; f < NUM_ATTR; f++) v[f*ATTR_W +: ATTR_W] = 32'h7fff_ffff;
      send_corner(v, 1'b0);
      for (int f = 0; f < NUM_ATTR; f++) v[f*ATTR_W +: ATTR_W] = 32'h7f80_0000;
      send_corner(v, 1'b0);
      for (int f = 0; f < NUM_ATTR; f++) v[f*ATTR_W +: ATTR_W] = 32'hff80_0000;
      send_corner(v, 1'b0);
      v[ATTR_W-1:0] = 32'h3f80_0000;
      send_corner(v, 1'b0);
      send_corner('0, 1'b0);
      send_corner({VTX_W{1'b1}}, 1'b1);
      send_corner(VTX_W'(32'h4000_0000), 1'b1);
      send_run(3);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // overflow runs, then mostly short runs
      send_run(34);
      while (corners_sent < 125) begin
         if (corners_sent > 105) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) send_run($urandom_range(30, 33));
         else send_run($urandom_range(1, 8));
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("%0d corners in %0d runs (%0d with dropped corners), %0d responses checked",
               corners_sent, run_count, overflow_runs, record_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_vertex_dedup_sort_remap passed");
      end else begin
         $display("tb_vertex_dedup_sort_remap failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_vertex_dedup_sort_remap failed");
      $finish;
   end

endmodule
